// ===== src/fft_pkg.sv =====
// Shared types, constants and twiddle ROM of the radix-2 FFT engine.
package fft_pkg;

   localparam int WORD_BITS      = 28;
   localparam int TW_BITS        = 16;
   localparam int BIN_INDEX_BITS = 6;
   localparam int ROM_LOG        = 6;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 8;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOG_SIZE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INVERSE  = 2'd1;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] re;
      logic signed [WORD_BITS-1:0] im;
   } word_type;

   typedef struct packed {
      logic signed [TW_BITS-1:0] re;
      logic signed [TW_BITS-1:0] im;
   } tw_type;

   // half wave cosine, Q1.15, +1.0 saturated
   function automatic logic signed [TW_BITS-1:0] cos_rom(input logic [4:0] t);
      logic signed [TW_BITS-1:0] v;
      unique case (t)
         5'd0:  v = 16'sd32767;   5'd1:  v = 16'sd32610;
         5'd2:  v = 16'sd32138;   5'd3:  v = 16'sd31357;
         5'd4:  v = 16'sd30274;   5'd5:  v = 16'sd28899;
         5'd6:  v = 16'sd27246;   5'd7:  v = 16'sd25330;
         5'd8:  v = 16'sd23170;   5'd9:  v = 16'sd20788;
         5'd10: v = 16'sd18205;   5'd11: v = 16'sd15447;
         5'd12: v = 16'sd12540;   5'd13: v = 16'sd9512;
         5'd14: v = 16'sd6393;    5'd15: v = 16'sd3212;
         5'd16: v = 16'sd0;       5'd17: v = -16'sd3212;
         5'd18: v = -16'sd6393;   5'd19: v = -16'sd9512;
         5'd20: v = -16'sd12540;  5'd21: v = -16'sd15447;
         5'd22: v = -16'sd18205;  5'd23: v = -16'sd20788;
         5'd24: v = -16'sd23170;  5'd25: v = -16'sd25330;
         5'd26: v = -16'sd27246;  5'd27: v = -16'sd28899;
         5'd28: v = -16'sd30274;  5'd29: v = -16'sd31357;
         5'd30: v = -16'sd32138;  5'd31: v = -16'sd32610;
         default: v = 16'sd0;
      endcase
      return v;
   endfunction

   // twiddle cos -/+ j sin; sine taken from the cosine table
   function automatic tw_type twiddle(input logic [4:0] t, input logic inv);
      tw_type w;
      logic signed [TW_BITS-1:0] sn;
      sn   = (t <= 5'd16) ? cos_rom(5'd16 - t) : cos_rom(t - 5'd16);
      w.re = cos_rom(t);
      w.im = inv ? sn : -sn;
      return w;
   endfunction

endpackage

// ===== src/radix2_fft_engine.sv =====
// Top level of the radix-2 decimation-in-time FFT engine.
// Usage: write log_size (index 0) and inverse_mode (index 1) on the csr_
// channel while the engine is idle; csr_ready is always high. Feed complex
// samples with start; a word is taken at a clock edge where start is high
// and busy is low, one per cycle, and stored at the next load address.
// When the sample for address N-1 arrives the engine raises busy and
// transforms in place in a single work memory (one write, two reads):
//   bit-reverse pass: SWAP_RD per address, SWAP_WA then SWAP_WB per swap,
//   butterflies: BF_RD, BF_MUL, BF_WA, BF_WB each, (N/2)*log2(N) of them,
//   one shared unit; output: one bin per cycle in natural order.
// Each bin shows on rsp_ for one cycle with rsp_valid high; rsp_last_bin
// marks bin N-1. The receiver cannot stall: bins are not held. busy drops
// with the last memory read, so loading of the next frame may overlap the
// final bin. Accesses of one butterfly finish before the next starts, so
// no forwarding. Reset clears the load address and registers (log_size 6,
// forward mode); the work memory holds garbage until loaded.
module radix2_fft_engine #(
   parameter int LOG2_MAX_POINTS = 6,
   parameter int SAMPLE_BITS     = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [SAMPLE_BITS-1:0]          req_sample_real,
   input  logic signed [SAMPLE_BITS-1:0]          req_sample_imag,
   output logic                                   rsp_valid,
   output logic signed [fft_pkg::WORD_BITS-1:0]   rsp_bin_real,
   output logic signed [fft_pkg::WORD_BITS-1:0]   rsp_bin_imag,
   output logic [fft_pkg::BIN_INDEX_BITS-1:0]     rsp_bin_index,
   output logic                                   rsp_last_bin,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [fft_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [fft_pkg::CSR_DATA_BITS-1:0]      csr_data
);
   import fft_pkg::*;

   localparam int AW    = LOG2_MAX_POINTS;
   localparam int DEPTH = 1 << AW;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SWAP_RD, ST_SWAP_WA, ST_SWAP_WB,
      ST_BF_RD, ST_BF_MUL, ST_BF_WA, ST_BF_WB, ST_EMIT
   } state_type;

   state_type         state_ff;
   logic [2:0]        log_size_ff;
   logic              inverse_ff;
   logic [AW-1:0]     load_count_ff;
   logic [AW-1:0]     idx_ff;      // swap / butterfly / emit counter
   logic [2:0]        stage_ff;
   tw_type            tw_ff;
   logic              rsp_valid_ff, rsp_last_ff;
   logic [AW-1:0]     rsp_idx_ff;

   word_type          mem [DEPTH];
   word_type          rd0_ff, rd1_ff;
   logic              rd_en, we;
   logic [AW-1:0]     ra0, ra1, wa;
   word_type          wd, sum_w, diff_w;

   logic [2:0]        lg;
   logic [AW-1:0]     n_m1, rev_i, half, mask, addr_a, addr_b;
   logic [5:0]        t6;
   logic              accept;

   // bit reversal over the active length
   function automatic logic [AW-1:0] rev_bits(input logic [AW-1:0] x, input logic [2:0] l);
      logic [AW-1:0] r;
      for (int b = 0; b < AW; b++) r[b] = x[AW-1-b];
      return r >> (3'(AW) - l);
   endfunction

   // effective length, bit-reversed index, butterfly addresses and twiddle index
   always_comb begin
      priority if (log_size_ff == 3'd0) lg = 3'd1;
      else if (log_size_ff > 3'(AW))    lg = 3'(AW);
      else                              lg = log_size_ff;
      n_m1   = {AW{1'b1}} >> (3'(AW) - lg);
      rev_i  = rev_bits(idx_ff, lg);
      half   = AW'(1) << (stage_ff - 3'd1);
      mask   = half - AW'(1);
      addr_a = ((idx_ff & ~mask) << 1) | (idx_ff & mask);
      addr_b = addr_a | half;
      t6     = 6'(idx_ff & mask) << (3'(ROM_LOG) - stage_ff);
   end

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   fft_bfly u_bfly (
      .clock  (clock),
      .mul_en (state_ff == ST_BF_MUL),
      .u_i    (rd0_ff),
      .b_i    (rd1_ff),
      .tw_i   (tw_ff),
      .sum_o  (sum_w),
      .diff_o (diff_w)
   );

   // memory port control
   always_comb begin
      rd_en = 1'b0;
      ra0   = idx_ff;
      ra1   = rev_i;
      we    = 1'b0;
      wa    = load_count_ff;
      wd.re = WORD_BITS'(req_sample_real);
      wd.im = WORD_BITS'(req_sample_imag);
      unique case (state_ff)
         ST_IDLE:    we = accept;
         ST_SWAP_RD: rd_en = (rev_i > idx_ff);
         ST_SWAP_WA: begin we = 1'b1; wa = idx_ff; wd = rd1_ff; end
         ST_SWAP_WB: begin we = 1'b1; wa = rev_i;  wd = rd0_ff; end
         ST_BF_RD:   begin rd_en = 1'b1; ra0 = addr_a; ra1 = addr_b; end
         ST_BF_MUL:  ;
         ST_BF_WA:   begin we = 1'b1; wa = addr_a; wd = sum_w;  end
         ST_BF_WB:   begin we = 1'b1; wa = addr_b; wd = diff_w; end
         ST_EMIT:    rd_en = 1'b1;
         default:    ;
      endcase
   end

   // work memory, registered reads
   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      if (rd_en) begin
         rd0_ff <= mem[ra0];
         rd1_ff <= mem[ra1];
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         log_size_ff   <= 3'd6;
         inverse_ff    <= 1'b0;
         load_count_ff <= '0;
         idx_ff        <= '0;
         stage_ff      <= 3'd1;
         rsp_valid_ff  <= 1'b0;
         rsp_last_ff   <= 1'b0;
         rsp_idx_ff    <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_LOG_SIZE) log_size_ff <= csr_data[2:0];
            if (csr_index == CSR_INVERSE)  inverse_ff  <= csr_data[0];
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (load_count_ff >= n_m1) begin
                     load_count_ff <= '0;
                     idx_ff        <= '0;
                     state_ff      <= ST_SWAP_RD;
                  end else begin
                     load_count_ff <= load_count_ff + AW'(1);
                  end
               end
            end
            ST_SWAP_RD, ST_SWAP_WB: begin
               if (state_ff == ST_SWAP_RD && rev_i > idx_ff) begin
                  state_ff <= ST_SWAP_WA;
               end else if (idx_ff == n_m1) begin
                  idx_ff   <= '0;
                  stage_ff <= 3'd1;
                  state_ff <= ST_BF_RD;
               end else begin
                  idx_ff   <= idx_ff + AW'(1);
                  state_ff <= ST_SWAP_RD;
               end
            end
            ST_SWAP_WA: state_ff <= ST_SWAP_WB;
            ST_BF_RD: begin
               tw_ff    <= twiddle(t6[4:0], inverse_ff);
               state_ff <= ST_BF_MUL;
            end
            ST_BF_MUL: state_ff <= ST_BF_WA;
            ST_BF_WA:  state_ff <= ST_BF_WB;
            ST_BF_WB: begin
               if (idx_ff == (n_m1 >> 1)) begin
                  idx_ff <= '0;
                  if (stage_ff == lg) begin
                     state_ff <= ST_EMIT;
                  end else begin
                     stage_ff <= stage_ff + 3'd1;
                     state_ff <= ST_BF_RD;
                  end
               end else begin
                  idx_ff   <= idx_ff + AW'(1);
                  state_ff <= ST_BF_RD;
               end
            end
            ST_EMIT: begin
               rsp_valid_ff <= 1'b1;
               rsp_idx_ff   <= idx_ff;
               rsp_last_ff  <= (idx_ff == n_m1);
               if (idx_ff == n_m1) state_ff <= ST_IDLE;
               idx_ff <= idx_ff + AW'(1);
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bin_real  = rd0_ff.re;
   assign rsp_bin_imag  = rd0_ff.im;
   assign rsp_bin_index = BIN_INDEX_BITS'(rsp_idx_ff);
   assign rsp_last_bin  = rsp_last_ff;

   // a bin word only follows an output read
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_EMIT))
      else $error("bin word without output read");

   // last marker only on a valid bin
   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_last_bin |-> rsp_valid)
      else $error("last marker without bin word");

   // completing a frame starts the transform
   a_frame_go: assert property (@(posedge clock) disable iff (reset)
      (accept && load_count_ff >= n_m1) |=> (state_ff == ST_SWAP_RD))
      else $error("full frame did not start transform");

   // no memory write while emitting
   a_emit_ro: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> !we)
      else $error("memory write during output");

endmodule

// ===== src/fft_bfly.sv =====
// Butterfly datapath: registered complex multiply, rounding, sum and difference.
module fft_bfly (
   input  logic             clock,
   input  logic             mul_en,
   input  fft_pkg::word_type u_i,
   input  fft_pkg::word_type b_i,
   input  fft_pkg::tw_type   tw_i,
   output fft_pkg::word_type sum_o,
   output fft_pkg::word_type diff_o
);
   import fft_pkg::*;

   localparam int PROD_BITS = WORD_BITS + TW_BITS;

   logic signed [PROD_BITS-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   word_type                    u_ff;
   logic signed [PROD_BITS:0]   t_re_full, t_im_full, t_re_sh, t_im_sh;
   logic signed [WORD_BITS-1:0] t_re, t_im;

   // partial products, one register stage
   always_ff @(posedge clock) begin
      if (mul_en) begin
         p_rr_ff <= b_i.re * tw_i.re;
         p_ii_ff <= b_i.im * tw_i.im;
         p_ri_ff <= b_i.re * tw_i.im;
         p_ir_ff <= b_i.im * tw_i.re;
         u_ff    <= u_i;
      end
   end

   // round half up, then arithmetic shift by 15
   always_comb begin
      t_re_full = (PROD_BITS+1)'(p_rr_ff) - (PROD_BITS+1)'(p_ii_ff) + (PROD_BITS+1)'(16384);
      t_im_full = (PROD_BITS+1)'(p_ri_ff) + (PROD_BITS+1)'(p_ir_ff) + (PROD_BITS+1)'(16384);
      t_re_sh   = t_re_full >>> 15;
      t_im_sh   = t_im_full >>> 15;
      t_re      = t_re_sh[WORD_BITS-1:0];
      t_im      = t_im_sh[WORD_BITS-1:0];
      sum_o.re  = u_ff.re + t_re;
      sum_o.im  = u_ff.im + t_im;
      diff_o.re = u_ff.re - t_re;
      diff_o.im = u_ff.im - t_im;
   end

endmodule

// ===== sim/radix2_fft_engine_tb.sv =====
// Self-checking testbench for the radix-2 FFT engine: frames of samples in, bins checked.
module radix2_fft_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fft_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd2;
   localparam int WATCHDOG_LIMIT = 6000;

   typedef struct {
      logic [WORD_BITS-1:0]      re;
      logic [WORD_BITS-1:0]      im;
      logic [BIN_INDEX_BITS-1:0] idx;
      logic                      last;
   } bin_word_type;

   // fft predictor and store of expected bins
   class fft_scoreboard;
      bin_word_type expected_bins[$];
      longint  store_re[64];
      longint  store_im[64];
      int      load_ptr;
      int      log_size;
      bit      inverse;
      int      errors;
      int      bins_checked;
      int      frames;
      int      samples;
      int      cos_q15[32] = '{
         32767, 32610, 32138, 31357, 30274, 28899, 27246, 25330,
         23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212,
         0, -3212, -6393, -9512, -12540, -15447, -18205, -20788,
         -23170, -25330, -27246, -28899, -30274, -31357, -32138, -32610};

      function new();
         load_ptr = 0;
         log_size = 6;
         inverse  = 0;
      endfunction

      function int eff_log();
         if (log_size < 1) return 1;
         if (log_size > 6) return 6;
         return log_size;
      endfunction

      function longint wrap(longint v);
         logic signed [WORD_BITS-1:0] w;
         w = v[WORD_BITS-1:0];
         return longint'(w);
      endfunction

      function void write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] d);
         if (idx == CSR_LOG_SIZE) log_size = d[2:0];
         else if (idx == CSR_INVERSE) inverse = d[0];
      endfunction

      function void transform(int lg);
         int n, r, x, st, sz, hf, base, k, a, b, t;
         longint wr, sn, wi, tr, ti, ur, ui, tmp;
         n = 1 << lg;
         // bit-reversed reorder
         for (int i = 0; i < n; i++) begin
            r = 0;
            x = i;
            for (int j = 0; j < lg; j++) begin
               r = (r << 1) | (x & 1);
               x = x >> 1;
            end
            if (r > i) begin
               tmp = store_re[i]; store_re[i] = store_re[r]; store_re[r] = tmp;
               tmp = store_im[i]; store_im[i] = store_im[r]; store_im[r] = tmp;
            end
         end
         // butterfly stages, products rounded half up
         for (st = 1; st <= lg; st++) begin
            sz = 1 << st;
            hf = sz >> 1;
            for (base = 0; base < n; base += sz) begin
               for (k = 0; k < hf; k++) begin
                  a  = base + k;
                  b  = a + hf;
                  t  = (k << (6 - st)) & 31;
                  wr = cos_q15[t];
                  sn = (t <= 16) ? cos_q15[16 - t] : cos_q15[t - 16];
                  wi = inverse ? sn : -sn;
                  tr = (store_re[b] * wr - store_im[b] * wi + 16384) >>> 15;
                  ti = (store_re[b] * wi + store_im[b] * wr + 16384) >>> 15;
                  ur = store_re[a];
                  ui = store_im[a];
                  store_re[a] = wrap(ur + tr);
                  store_im[a] = wrap(ui + ti);
                  store_re[b] = wrap(ur - tr);
                  store_im[b] = wrap(ui - ti);
               end
            end
         end
      endfunction

      // accepted sample: store it, run the frame when complete
      function void note_sample(logic signed [15:0] re, logic signed [15:0] im);
         int lg, n;
         bin_word_type w;
         lg = eff_log();
         n  = 1 << lg;
         samples++;
         store_re[load_ptr] = re;
         store_im[load_ptr] = im;
         if (load_ptr < n - 1) begin
            load_ptr++;
            return;
         end
         load_ptr = 0;
         frames++;
         transform(lg);
         for (int k = 0; k < n; k++) begin
            w.re   = store_re[k][WORD_BITS-1:0];
            w.im   = store_im[k][WORD_BITS-1:0];
            w.idx  = BIN_INDEX_BITS'(k);
            w.last = (k == n - 1);
            expected_bins.push_back(w);
         end
      endfunction

      function void check_bin(bin_word_type got);
         bin_word_type w;
         if (expected_bins.size() == 0) begin
            $display("%0t: unexpected bin idx %0d", $time, got.idx);
            errors++;
            return;
         end
         w = expected_bins.pop_front();
         bins_checked++;
         if (got.re !== w.re || got.im !== w.im || got.idx !== w.idx || got.last !== w.last) begin
            $display("%0t: bin mismatch exp re %0d im %0d idx %0d last %0d", $time,
                     $signed(w.re), $signed(w.im), w.idx, w.last);
            $display("%0t:              got re %0d im %0d idx %0d last %0d", $time,
                     $signed(got.re), $signed(got.im), got.idx, got.last);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [15:0] req_sample_real = '0;
   logic signed [15:0] req_sample_imag = '0;
   logic rsp_valid;
   logic signed [WORD_BITS-1:0] rsp_bin_real, rsp_bin_imag;
   logic [BIN_INDEX_BITS-1:0] rsp_bin_index;
   logic rsp_last_bin;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   fft_scoreboard sb = new();
   int idle_pct = 0;
   int quiet_cycles = 0;

   radix2_fft_engine uut (.*);

   always #4 clock = ~clock;

   // monitor: configuration writes, accepted samples, bins
   always @(posedge clock) begin
      bin_word_type got;
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (rsp_valid) begin
            got.re   = rsp_bin_real;
            got.im   = rsp_bin_imag;
            got.idx  = rsp_bin_index;
            got.last = rsp_last_bin;
            sb.check_bin(got);
         end
         if (start && !busy) sb.note_sample(req_sample_real, req_sample_imag);
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles", quiet_cycles);
            $display("radix2_fft_engine_tb: errors");
            $finish;
         end
      end
   end

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] d);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= d;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
   endtask

   // log_size goes with random upper bits to cover masking
   task automatic configure(int lg, bit inv);
      logic [7:0] r;
      r = 8'($urandom);
      write_csr(CSR_LOG_SIZE, {r[7:3], lg[2:0]});
      r = 8'($urandom);
      write_csr(CSR_INVERSE, {r[7:1], inv});
   endtask

   task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im);
      if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
         start <= 0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      start <= 1;
      req_sample_real <= re;
      req_sample_imag <= im;
      do @(posedge clock); while (busy);
   endtask

   // drop start, wait out the transform and all bins, then settle
   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (busy || sb.expected_bins.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_value();
      unique case ($urandom_range(5, 0))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(255, 0) - 128);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_frame_part(int count);
      for (int i = 0; i < count; i++) send_sample(pick_value(), pick_value());
   endtask

   initial begin
      int n, cnt, lg, sent;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, clamped sizes, inverse, ignored index
      configure(1, 0);
      send_sample(16'sh7FFF, -16'sh8000);
      send_sample(-16'sh8000, 16'sh7FFF);
      drain();
      configure(0, 1);
      send_sample(16'sh7FFF, 16'sh7FFF);
      send_sample(-16'sh8000, -16'sh8000);
      drain();
      write_csr(CSR_SPARE, 8'hFF);
      configure(2, 0);
      send_frame_part(4);
      drain();
      configure(3, 1);
      send_frame_part(8);
      drain();
      // length shrinks mid-frame: three loaded, then a 2-point run
      configure(3, 0);
      send_frame_part(3);
      drain();
      configure(1, 0);
      send_sample(16'sh1234, -16'sh0FED);
      drain();

      // random phases with different sender idling
      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = (ph == 0) ? 38 : (ph == 1) ? 45 : 0;
         sent = 0;
         cnt  = 0;
         while (sent < 170) begin
            lg = (cnt == 0) ? 6 : (cnt == 1) ? 7 : $urandom_range(7, 0);
            cnt++;
            configure(lg, $urandom_range(1, 0));
            n = 1 << ((lg < 1) ? 1 : (lg > 6) ? 6 : lg);
            if ($urandom_range(99, 0) < 85)
               cnt = (sb.load_ptr >= n - 1) ? cnt : cnt;
            if ($urandom_range(99, 0) < 85) n = (sb.load_ptr >= n - 1) ? 1 : n - sb.load_ptr;
            else n = $urandom_range(n, 1);
            send_frame_part(n);
            sent += n;
            drain();
         end
      end

      drain();
      $display("covered %0d samples, %0d frames, %0d bins checked across sizes 2..64",
               sb.samples, sb.frames, sb.bins_checked);
      if (sb.errors == 0 && sb.expected_bins.size() == 0)
         $display("radix2_fft_engine_tb: clean");
      else
         $display("radix2_fft_engine_tb: errors");
      $finish;
   end
endmodule

// ===== radix2_fft_engine.f =====
src/fft_pkg.sv
src/fft_bfly.sv
src/radix2_fft_engine.sv
sim/radix2_fft_engine_tb.sv
